// ----- rtl/core/ps2mct_pkg.sv -----
`timescale 1ns / 1ps

package ps2mct_pkg;

  // byte position within a three-byte packet
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DX     = 2'd1,
    PH_DY     = 2'd2
  } phase_e;

  // configuration register indexes
  localparam logic [1:0] REG_MOVE_SCALE    = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

  // configuration and payload widths
  localparam int unsigned SCALE_W   = 8;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OUT_W     = 12;

  // configuration reset values
  localparam logic [SCALE_W-1:0] SCALE_RST  = 8'd1;
  localparam logic [SIZE_W-1:0]  WIDTH_RST  = 13'd1024;
  localparam logic [SIZE_W-1:0]  HEIGHT_RST = 13'd768;

  // header byte bit positions
  localparam int unsigned HDR_LEFT   = 0;
  localparam int unsigned HDR_RIGHT  = 1;
  localparam int unsigned HDR_MIDDLE = 2;
  localparam int unsigned HDR_SYNC   = 3;
  localparam int unsigned HDR_XSIGN  = 4;
  localparam int unsigned HDR_YSIGN  = 5;
  localparam int unsigned HDR_XOVF   = 6;
  localparam int unsigned HDR_YOVF   = 7;

  // extra step added when a movement overflow bit is set
  localparam logic [7:0] OVF_STEP = 8'd255;

  // one complete packet waiting for the cursor update
  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] dy;
  } packet_t;

endpackage

// ----- rtl/core/ps2_mouse_packet_cursor_tracker.sv -----
`timescale 1ns / 1ps

// PS/2 mouse packet decoder with cursor tracking.
// Input channel: one mouse byte per transfer on rx_byte_i (in_valid_i / in_stall_o).
// Bytes are grouped into three-byte packets; a header byte must have its sync bit
// set, otherwise it is dropped. The third byte of a packet yields one result on the
// output channel (out_valid_o / out_stall_i): the clamped cursor position and the
// three button levels. Header and X bytes yield nothing.
// The third byte's transfer loads the packet register; the result register takes the
// result from it when the output is not stalled.
// Throughput: one byte per cycle while in_stall_o is low; the cursor update is one 9x8
// multiply, an add and a clamp per axis.
// When the receiver stalls, the result register holds; a packet waiting behind it
// holds too, and only then is in_stall_o raised (combinationally from out_stall_i).
// Configuration: cfg_valid_i/cfg_ready_o, cfg_index_i (0 move scale, 1 screen width,
// 2 screen height), cfg_data_i; always ready. Write only while idle (not enforced).
// Reset: asynchronous, active low. The cursor returns to (0,0), the packet phase to
// the header byte, scale to 1 and the screen to 1024 x 768.

module ps2_mouse_packet_cursor_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ps2mct_pkg::SIZE_W-1:0]       cfg_data_i,
  // byte input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ps2mct_pkg::BYTE_W-1:0]       rx_byte_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ps2mct_pkg::OUT_W-1:0]        cursor_x_o,
  output logic [ps2mct_pkg::OUT_W-1:0]        cursor_y_o,
  output logic                                left_pressed_o,
  output logic                                middle_pressed_o,
  output logic                                right_pressed_o
);

  localparam int unsigned MAG_W  = ps2mct_pkg::BYTE_W + 1;
  localparam int unsigned STEP_W = MAG_W + ps2mct_pkg::SCALE_W;
  localparam int unsigned SUM_W  = COORD_BITS + STEP_W + 2;
  localparam int unsigned OUT_W  = ps2mct_pkg::OUT_W;

  // configuration registers
  logic [ps2mct_pkg::SCALE_W-1:0] move_scale_q;
  logic [ps2mct_pkg::SIZE_W-1:0]  screen_width_q;
  logic [ps2mct_pkg::SIZE_W-1:0]  screen_height_q;

  // packet assembly
  ps2mct_pkg::phase_e             phase_q, phase_d;
  logic [ps2mct_pkg::BYTE_W-1:0]  header_q;
  logic [ps2mct_pkg::BYTE_W-1:0]  dx_q;
  logic                           hdr_load;
  logic                           dx_load;
  logic                           pkt_load;

  // packet register
  logic                           pkt_valid_q, pkt_valid_d;
  ps2mct_pkg::packet_t            pkt_q;

  // cursor state and result register
  logic [COORD_BITS-1:0]          pos_x_q, pos_y_q;
  logic [COORD_BITS-1:0]          pos_x_d, pos_y_d;
  logic                           out_valid_q;
  logic [OUT_W-1:0]               cursor_x_q, cursor_y_q;
  logic                           left_q, middle_q, right_q;

  logic                           in_xfer;
  logic                           adv;
  logic                           upd;

  // cursor update datapath
  logic [MAG_W-1:0]               mag_x, mag_y;
  logic [STEP_W-1:0]              step_x, step_y;
  logic signed [SUM_W-1:0]        sum_x, sum_y;
  logic signed [SUM_W-1:0]        top_x, top_y;
  logic [OUT_W+COORD_BITS-1:0]    ext_x, ext_y;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = pkt_valid_q && !adv;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign upd         = adv && pkt_valid_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_scale_q    <= ps2mct_pkg::SCALE_RST;
      screen_width_q  <= ps2mct_pkg::WIDTH_RST;
      screen_height_q <= ps2mct_pkg::HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ps2mct_pkg::REG_MOVE_SCALE:    move_scale_q    <= cfg_data_i[ps2mct_pkg::SCALE_W-1:0];
        ps2mct_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        ps2mct_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // packet phase next state
  always_comb begin
    phase_d = phase_q;
    if (in_xfer) begin
      case (phase_q)
        ps2mct_pkg::PH_DX: phase_d = ps2mct_pkg::PH_DY;
        ps2mct_pkg::PH_DY: phase_d = ps2mct_pkg::PH_HEADER;
        default: begin
          phase_d = rx_byte_i[ps2mct_pkg::HDR_SYNC] ? ps2mct_pkg::PH_DX
                                                    : ps2mct_pkg::PH_HEADER;
        end
      endcase
    end
  end

  // packet phase outputs: which register takes the byte
  always_comb begin
    hdr_load = 1'b0;
    dx_load  = 1'b0;
    pkt_load = 1'b0;
    if (in_xfer) begin
      case (phase_q)
        ps2mct_pkg::PH_DX: dx_load  = 1'b1;
        ps2mct_pkg::PH_DY: pkt_load = 1'b1;
        default:           hdr_load = rx_byte_i[ps2mct_pkg::HDR_SYNC];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ps2mct_pkg::PH_HEADER;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_load) begin
      header_q <= rx_byte_i;
    end
    if (dx_load) begin
      dx_q <= rx_byte_i;
    end
  end

  // packet register
  assign pkt_valid_d = pkt_load || (pkt_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_valid_q <= 1'b0;
    end else begin
      pkt_valid_q <= pkt_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_load) begin
      pkt_q.header <= header_q;
      pkt_q.dx     <= dx_q;
      pkt_q.dy     <= rx_byte_i;
    end
  end

  // movement magnitude: 256 minus the byte when the sign bit is set
  always_comb begin
    mag_x = pkt_q.header[ps2mct_pkg::HDR_XSIGN] ? (MAG_W'(256) - MAG_W'(pkt_q.dx))
                                                : MAG_W'(pkt_q.dx);
    mag_y = pkt_q.header[ps2mct_pkg::HDR_YSIGN] ? (MAG_W'(256) - MAG_W'(pkt_q.dy))
                                                : MAG_W'(pkt_q.dy);
  end

  // scaled step plus overflow extra
  always_comb begin
    step_x = STEP_W'(mag_x) * STEP_W'(move_scale_q)
           + (pkt_q.header[ps2mct_pkg::HDR_XOVF] ? STEP_W'(ps2mct_pkg::OVF_STEP) : '0);
    step_y = STEP_W'(mag_y) * STEP_W'(move_scale_q)
           + (pkt_q.header[ps2mct_pkg::HDR_YOVF] ? STEP_W'(ps2mct_pkg::OVF_STEP) : '0);
  end

  // new position before clamping; y is inverted
  always_comb begin
    if (pkt_q.header[ps2mct_pkg::HDR_XSIGN]) begin
      sum_x = $signed(SUM_W'(pos_x_q)) - $signed(SUM_W'(step_x));
    end else begin
      sum_x = $signed(SUM_W'(pos_x_q)) + $signed(SUM_W'(step_x));
    end
    if (pkt_q.header[ps2mct_pkg::HDR_YSIGN]) begin
      sum_y = $signed(SUM_W'(pos_y_q)) + $signed(SUM_W'(step_y));
    end else begin
      sum_y = $signed(SUM_W'(pos_y_q)) - $signed(SUM_W'(step_y));
    end
  end

  // clamp limits: screen size minus one, at most the coordinate range
  always_comb begin
    top_x = (screen_width_q == '0) ? '0 : $signed(SUM_W'(screen_width_q - 1'b1));
    top_y = (screen_height_q == '0) ? '0 : $signed(SUM_W'(screen_height_q - 1'b1));
    if (top_x > $signed(SUM_W'({COORD_BITS{1'b1}}))) begin
      top_x = $signed(SUM_W'({COORD_BITS{1'b1}}));
    end
    if (top_y > $signed(SUM_W'({COORD_BITS{1'b1}}))) begin
      top_y = $signed(SUM_W'({COORD_BITS{1'b1}}));
    end
  end

  // clamp to the screen
  always_comb begin
    if (sum_x < 0) begin
      pos_x_d = '0;
    end else if (sum_x > top_x) begin
      pos_x_d = top_x[COORD_BITS-1:0];
    end else begin
      pos_x_d = sum_x[COORD_BITS-1:0];
    end
    if (sum_y < 0) begin
      pos_y_d = '0;
    end else if (sum_y > top_y) begin
      pos_y_d = top_y[COORD_BITS-1:0];
    end else begin
      pos_y_d = sum_y[COORD_BITS-1:0];
    end
  end

  // low output bits of the position, zero padded for narrow coordinates
  assign ext_x = {{OUT_W{1'b0}}, pos_x_d};
  assign ext_y = {{OUT_W{1'b0}}, pos_y_d};

  // cursor state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pkt_valid_q;
      if (pkt_valid_q) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      cursor_x_q <= ext_x[OUT_W-1:0];
      cursor_y_q <= ext_y[OUT_W-1:0];
      left_q     <= pkt_q.header[ps2mct_pkg::HDR_LEFT];
      middle_q   <= pkt_q.header[ps2mct_pkg::HDR_MIDDLE];
      right_q    <= pkt_q.header[ps2mct_pkg::HDR_RIGHT];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cursor_x_o       = cursor_x_q;
  assign cursor_y_o       = cursor_y_q;
  assign left_pressed_o   = left_q;
  assign middle_pressed_o = middle_q;
  assign right_pressed_o  = right_q;

  // input is held back only by a packet waiting behind a stalled result
  a_stall_needs_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pkt_valid_q)
    else $error("input stalled with no packet waiting");

  // a packet moved on appears as a result
  a_packet_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> out_valid_o)
    else $error("packet update produced no result");

  // cursor holds while the result is stalled
  a_cursor_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(pos_x_q) && $stable(pos_y_q)))
    else $error("cursor moved during output stall");

  // a header byte without the sync bit is dropped
  a_sync_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && phase_q == ps2mct_pkg::PH_HEADER && !rx_byte_i[ps2mct_pkg::HDR_SYNC])
      |=> (phase_q == ps2mct_pkg::PH_HEADER))
    else $error("unsynced header byte left header phase");

endmodule
